// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, status codes and character classes of the policy text scanner.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Status codes; the whole-text codes 1 to 4 win in this order over the rest
  typedef enum logic [4:0] {
    ST_OK            = 5'd0,
    ST_TOO_LONG      = 5'd1,
    ST_BAD_WRAPPER   = 5'd2,
    ST_SH_PK         = 5'd3,
    ST_MUSIG         = 5'd4,
    ST_BAD_NUMBER    = 5'd5,
    ST_NUM_RANGE     = 5'd6,
    ST_UNKNOWN_KEY   = 5'd7,
    ST_KEY_ORDER     = 5'd8,
    ST_BAD_KEY_EXPR  = 5'd9,
    ST_OVERLAP       = 5'd10,
    ST_TOO_MANY_REFS = 5'd11,
    ST_BAD_CHAR      = 5'd12,
    ST_TOO_DEEP      = 5'd13,
    ST_UNBALANCED    = 5'd14,
    ST_TOO_MANY_WRAP = 5'd15,
    ST_INCOMPLETE    = 5'd16
  } status_e;

  // Position inside a key reference
  typedef enum logic [2:0] {
    PH_OUT,
    PH_KEY,
    PH_AFTER,
    PH_STAR2,
    PH_RECV,
    PH_CHG,
    PH_SLASH2,
    PH_STAR1
  } phase_e;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP,
    BK_SRCH,
    BK_WR1,
    BK_WR2,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } pts_in_t;

  typedef struct packed {
    logic [4:0]  status;
    logic        done_res;
    logic        ref_valid;
    logic [4:0]  ref_key;
    logic [30:0] ref_receive;
    logic [30:0] ref_change;
  } pts_out_t;

  // One classified character between front and back
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    status_e     wt_status;
    logic [13:0] lower_run;
  } pts_item_t;

  localparam logic [31:0] NUM_LIMIT = 32'h8000_0000;
  localparam logic [13:0] LRUN_MAX  = 14'h3FFF;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic allowed_char(input logic [7:0] c);
    return is_lower(c) || ((c >= "A") && (c <= "Z")) || is_digit(c) ||
           (c == "_") || (c == "(") || (c == ")") || (c == ":") ||
           (c == "{") || (c == "}") || (c == ",");
  endfunction

endpackage

// ===== rtl/policy_text_scanner.sv =====
// ----------------------------------------------------------------------------
// policy_text_scanner
// Checks a wallet policy text one character per request and reports each
// completed key reference together with a running status.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one character per request, last marks the end of the text.
//   out channel : one result per character, in order; done_res marks the
//                 final verdict, ref_valid marks a completed key reference.
//   cfg channel : always ready; the user must write key_count only while
//                 no text is in flight, which the block does not enforce.
// Flow:
//   A plain character is written into the queue at its accepting edge and
//   scanned from there into the output register; while the scanner is idle
//   and the receiver takes results, plain characters flow at one per cycle.
//   Closing a bracket two or more levels deep also passes BK_POP for the
//   nesting stack read. A completed reference walks the path table one entry
//   per cycle over the paths stored so far (two per earlier reference).
// Reset clears all text state and sets key_count to 1. The front accepts up
// to two characters ahead of the scanner; when the receiver stalls, the
// output register holds its result and the queue fills, then in_ready_o
// drops.
// ----------------------------------------------------------------------------
module policy_text_scanner
  import pts_pkg::*;
#(
  parameter int MAX_KEYS     = 32,
  parameter int MAX_REFS     = 128,
  parameter int MAX_NEST     = 64,
  parameter int MAX_TEXT     = 8192,
  parameter int MAX_WRAPPERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pts_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pts_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i
);

  logic [5:0] key_count_q;
  logic [5:0] eff_keys;
  logic       full;
  logic       push;
  pts_item_t  push_data;
  logic       q_valid;
  logic       q_pop;
  pts_item_t  q_data;

  // Key count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= 6'd1;
    end else if (cfg_valid_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  // Clamp key count into its legal range
  always_comb begin
    if (key_count_q == 6'd0) begin
      eff_keys = 6'd1;
    end else if (key_count_q > 6'(MAX_KEYS)) begin
      eff_keys = 6'(MAX_KEYS);
    end else begin
      eff_keys = key_count_q;
    end
  end

  pts_front #(.MAX_TEXT(MAX_TEXT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pts_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  pts_back #(
    .MAX_KEYS     (MAX_KEYS),
    .MAX_REFS     (MAX_REFS),
    .MAX_NEST     (MAX_NEST),
    .MAX_WRAPPERS (MAX_WRAPPERS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .pop_o        (q_pop),
    .item_i       (q_data),
    .eff_keys_i   (eff_keys),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== rtl/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/pts_front.sv =====
// ----------------------------------------------------------------------------
// pts_front
// Accepts characters, tracks length, leading wrapper, musig and lowercase
// runs, and pushes classified requests toward the back end.
// ----------------------------------------------------------------------------
module pts_front
  import pts_pkg::*;
#(
  parameter int MAX_TEXT = 8192
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pts_in_t   in_data_i,
  input  logic      full_i,
  output logic      push_o,
  output pts_item_t push_data_o
);

  localparam int CCW = $clog2(MAX_TEXT + 2);

  // Prefix patterns, first character in the low byte
  localparam logic [47:0] P_PKH  = {16'h0, "(hkp"};
  localparam logic [47:0] P_WPKH = {8'h0, "(hkpw"};
  localparam logic [47:0] P_SH   = {24'h0, "(hs"};
  localparam logic [47:0] P_WSH  = {16'h0, "(hsw"};
  localparam logic [47:0] P_TR   = {24'h0, "(rt"};
  localparam logic [47:0] P_SHPK = "(kp(hs";

  logic [CCW-1:0] cc_q, cc_d;
  logic [47:0]    buf_q, buf_d;
  logic [2:0]     mm_q, mm_d;
  logic           mf_q, mf_d;
  logic [13:0]    lrun_q, lrun_d;
  logic           accept;
  logic [2:0]     n_seen;
  logic           pfx_ok;
  status_e        wt;

  function automatic logic [7:0] musig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = "m";
      3'd1:    b = "u";
      3'd2:    b = "s";
      3'd3:    b = "i";
      3'd4:    b = "g";
      default: b = "(";
    endcase
    return b;
  endfunction

  // Prefix may still match (or does match on the final character)
  function automatic logic prefix_is(input logic [47:0] buff, input logic [2:0] n,
                                     input logic [47:0] pat, input logic [2:0] len,
                                     input logic fin);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if ((3'(i) < len) && (3'(i) < n) && (buff[8*i +: 8] != pat[8*i +: 8])) begin
        eq = 1'b0;
      end
    end
    return eq && ((len <= n) || !fin);
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Next state of the whole-text trackers
  always_comb begin
    cc_d  = cc_q;
    buf_d = buf_q;
    mm_d  = mm_q;
    mf_d  = mf_q;
    if (cc_q < CCW'(6)) begin
      buf_d[8*cc_q[2:0] +: 8] = in_data_i.ch;
    end
    if (cc_q <= CCW'(MAX_TEXT)) begin
      cc_d = cc_q + 1'b1;
    end
    if (!mf_q) begin
      if ((mm_q < 3'd6) && (in_data_i.ch == musig_byte(mm_q))) begin
        if (mm_q == 3'd5) begin
          mf_d = 1'b1;
          mm_d = 3'd0;
        end else begin
          mm_d = mm_q + 1'b1;
        end
      end else begin
        mm_d = (in_data_i.ch == "m") ? 3'd1 : 3'd0;
      end
    end
    if (is_lower(in_data_i.ch)) begin
      lrun_d = (lrun_q < LRUN_MAX) ? lrun_q + 1'b1 : lrun_q;
    end else begin
      lrun_d = '0;
    end
  end

  // Whole-text verdict after this character
  always_comb begin
    n_seen = (cc_d < CCW'(6)) ? cc_d[2:0] : 3'd6;
    pfx_ok = prefix_is(buf_d, n_seen, P_PKH, 3'd4, in_data_i.last) ||
             prefix_is(buf_d, n_seen, P_WPKH, 3'd5, in_data_i.last) ||
             prefix_is(buf_d, n_seen, P_SH, 3'd3, in_data_i.last) ||
             prefix_is(buf_d, n_seen, P_WSH, 3'd4, in_data_i.last) ||
             prefix_is(buf_d, n_seen, P_TR, 3'd3, in_data_i.last);
    if (cc_d > CCW'(MAX_TEXT)) begin
      wt = ST_TOO_LONG;
    end else if (!pfx_ok) begin
      wt = ST_BAD_WRAPPER;
    end else if ((cc_d >= CCW'(6)) && (buf_d == P_SHPK)) begin
      wt = ST_SH_PK;
    end else if (mf_d) begin
      wt = ST_MUSIG;
    end else begin
      wt = ST_OK;
    end
    push_data_o.ch        = in_data_i.ch;
    push_data_o.last      = in_data_i.last;
    push_data_o.wt_status = wt;
    push_data_o.lower_run = lrun_q;
  end

  // Tracker registers, cleared after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      buf_q  <= '0;
      mm_q   <= '0;
      mf_q   <= 1'b0;
      lrun_q <= '0;
    end else if (accept) begin
      if (in_data_i.last) begin
        cc_q   <= '0;
        buf_q  <= '0;
        mm_q   <= '0;
        mf_q   <= 1'b0;
        lrun_q <= '0;
      end else begin
        cc_q   <= cc_d;
        buf_q  <= buf_d;
        mm_q   <= mm_d;
        mf_q   <= mf_d;
        lrun_q <= lrun_d;
      end
    end
  end

endmodule

// ===== rtl/pts_fifo.sv =====
// ----------------------------------------------------------------------------
// pts_fifo
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module pts_fifo
  import pts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pts_item_t push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output pts_item_t pop_data_o
);

  pts_item_t  ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = ent_q[rp_q];

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/pts_back.sv =====
// ----------------------------------------------------------------------------
// pts_back
// Reference and bracket scanner: parses key references, keeps the nesting
// stack and searches the path table, then registers one result per request.
// ----------------------------------------------------------------------------
module pts_back
  import pts_pkg::*;
#(
  parameter int MAX_KEYS     = 32,
  parameter int MAX_REFS     = 128,
  parameter int MAX_NEST     = 64,
  parameter int MAX_WRAPPERS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      pop_o,
  input  pts_item_t item_i,
  input  logic [5:0] eff_keys_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pts_out_t  out_data_o
);

  localparam int DW  = $clog2(MAX_NEST + 1);
  localparam int SAW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam int PD  = 2 * MAX_REFS;
  localparam int PAW = $clog2(PD);
  localparam int PCW = $clog2(PD + 1);
  localparam int RCW = $clog2(MAX_REFS + 1);
  localparam int WW  = $clog2(MAX_WRAPPERS + 2);
  localparam int KIW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  back_state_e         st_q, st_d;
  phase_e              phase_q, phase_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic                top_q, top_d;
  logic [31:0]         acc_q, acc_d;
  logic [3:0]          dc_q, dc_d;
  logic                lz_q, lz_d;
  logic [4:0]          key_q, key_d;
  logic [30:0]         recv_q, recv_d;
  logic [MAX_KEYS-1:0] seen_q, seen_d;
  logic [5:0]          nnk_q, nnk_d;
  logic [RCW-1:0]      rc_q, rc_d;
  logic [PCW-1:0]      pc_q, pc_d;
  logic [WW-1:0]       wr_q, wr_d;
  status_e             err_q, err_d;
  logic [PCW-1:0]      ridx_q, ridx_d;
  logic                cmpv_q, cmpv_d;
  logic                refv_q, refv_d;
  logic                ov_q, ov_d;
  pts_item_t           itm_q, itm_d;
  logic [30:0]         prec_q, prec_d;
  logic [30:0]         pchg_q, pchg_d;
  pts_out_t            out_q, out_d;

  logic                stk_we;
  logic [SAW-1:0]      stk_waddr, stk_raddr;
  logic                stk_rdata;
  logic                pt_we;
  logic [PAW-1:0]      pt_waddr, pt_raddr;
  logic [35:0]         pt_wdata, pt_rdata;

  function automatic logic [31:0] acc_add(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, d};
    return (v >= {4'b0, NUM_LIMIT}) ? NUM_LIMIT : v[31:0];
  endfunction

  function automatic status_e num_code(input logic [31:0] acc, input logic [3:0] dc,
                                       input logic lz);
    status_e s;
    if ((dc == 4'd0) || (lz && (dc > 4'd1))) begin
      s = ST_BAD_NUMBER;
    end else if (acc[31]) begin
      s = ST_NUM_RANGE;
    end else begin
      s = ST_OK;
    end
    return s;
  endfunction

  function automatic status_e key_code(input logic [31:0] acc, input logic [3:0] dc,
                                       input logic lz, input logic [5:0] eff,
                                       input logic [MAX_KEYS-1:0] seen,
                                       input logic [5:0] nnk);
    status_e s;
    s = num_code(acc, dc, lz);
    if (s == ST_OK) begin
      if (acc >= {26'b0, eff}) begin
        s = ST_UNKNOWN_KEY;
      end else if (!seen[acc[KIW-1:0]] && (acc[5:0] != nnk)) begin
        s = ST_KEY_ORDER;
      end
    end
    return s;
  endfunction

  function automatic status_e fin_status(input status_e wt, input status_e err,
                                         input logic last, input logic open_nest,
                                         input logic [5:0] nnk, input logic [5:0] eff);
    status_e s;
    s = (wt != ST_OK) ? wt : err;
    if (last && (s == ST_OK) && (open_nest || (nnk != eff))) begin
      s = ST_INCOMPLETE;
    end
    return s;
  endfunction

  // Nesting stack below the top entry
  pts_ram #(.WIDTH(1), .DEPTH(MAX_NEST)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (top_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Path table: key in the top bits, path number below
  pts_ram #(.WIDTH(36), .DEPTH(PD)) u_paths (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // Scan, search and result sequencing
  always_comb begin
    logic [7:0]  c;
    logic        out_free;
    logic        need_pop;
    logic        need_ref;
    logic [30:0] r_recv;
    logic [30:0] r_chg;
    logic [15:0] wsum;
    status_e     e;
    status_e     s;
    logic        do_clear;

    st_d     = st_q;
    phase_d  = phase_q;
    depth_d  = depth_q;
    top_d    = top_q;
    acc_d    = acc_q;
    dc_d     = dc_q;
    lz_d     = lz_q;
    key_d    = key_q;
    recv_d   = recv_q;
    seen_d   = seen_q;
    nnk_d    = nnk_q;
    rc_d     = rc_q;
    pc_d     = pc_q;
    wr_d     = wr_q;
    err_d    = err_q;
    ridx_d   = ridx_q;
    cmpv_d   = cmpv_q;
    refv_d   = refv_q;
    itm_d    = itm_q;
    prec_d   = prec_q;
    pchg_d   = pchg_q;
    out_free = !ov_q || out_ready_i;
    ov_d     = ov_q && !out_ready_i;
    out_d    = out_q;
    pop_o    = 1'b0;
    stk_we   = 1'b0;
    stk_waddr = SAW'(depth_q - 1'b1);
    stk_raddr = SAW'(depth_q - 2'd2);
    pt_we    = 1'b0;
    pt_waddr = pc_q[PAW-1:0];
    pt_wdata = {key_q, prec_q};
    pt_raddr = ridx_q[PAW-1:0];
    c        = item_i.ch;
    need_pop = 1'b0;
    need_ref = 1'b0;
    r_recv   = 31'd0;
    r_chg    = 31'd1;
    wsum     = 16'd0;
    e        = ST_OK;
    s        = ST_OK;
    do_clear = 1'b0;

    case (st_q)
      BK_IDLE: begin
        if (item_valid_i && out_free) begin
          pop_o = 1'b1;
          itm_d = item_i;
          if (err_q == ST_OK) begin
            case (phase_q)
              PH_OUT: begin
                if (c == "@") begin
                  phase_d = PH_KEY;
                  acc_d   = '0;
                  dc_d    = '0;
                  lz_d    = 1'b0;
                end else if (!allowed_char(c)) begin
                  err_d = ST_BAD_CHAR;
                end else if ((c == "(") || (c == "{")) begin
                  if (depth_q >= DW'(MAX_NEST)) begin
                    err_d = ST_TOO_DEEP;
                  end else begin
                    stk_we  = (depth_q != '0);
                    top_d   = (c == "{");
                    depth_d = depth_q + 1'b1;
                  end
                end else if ((c == ")") || (c == "}")) begin
                  if ((depth_q == '0) || (top_q != (c == "}"))) begin
                    err_d = ST_UNBALANCED;
                  end else begin
                    depth_d  = depth_q - 1'b1;
                    need_pop = (depth_q > DW'(1));
                  end
                end else if (c == ":") begin
                  wsum = 16'(wr_q) + {2'b0, item_i.lower_run};
                  if (wsum > 16'(MAX_WRAPPERS)) begin
                    wr_d  = WW'(MAX_WRAPPERS + 1);
                    err_d = ST_TOO_MANY_WRAP;
                  end else begin
                    wr_d = wsum[WW-1:0];
                  end
                end
              end
              PH_KEY: begin
                if (is_digit(c)) begin
                  lz_d  = (dc_q == 4'd0) ? (c == "0") : lz_q;
                  dc_d  = (dc_q < 4'd15) ? dc_q + 1'b1 : dc_q;
                  acc_d = acc_add(acc_q, 4'(c - "0"));
                end else begin
                  e = key_code(acc_q, dc_q, lz_q, eff_keys_i, seen_q, nnk_q);
                  if (e != ST_OK) begin
                    err_d = e;
                  end else begin
                    if (!seen_q[acc_q[KIW-1:0]]) begin
                      seen_d[acc_q[KIW-1:0]] = 1'b1;
                      nnk_d = nnk_q + 1'b1;
                    end
                    key_d = acc_q[4:0];
                    if (c == "/") begin
                      phase_d = PH_AFTER;
                    end else begin
                      err_d = ST_BAD_KEY_EXPR;
                    end
                  end
                end
              end
              PH_AFTER: begin
                if (c == "*") begin
                  phase_d = PH_STAR2;
                end else if (c == "<") begin
                  phase_d = PH_RECV;
                  acc_d   = '0;
                  dc_d    = '0;
                  lz_d    = 1'b0;
                end else begin
                  err_d = ST_BAD_KEY_EXPR;
                end
              end
              PH_STAR2: begin
                if (c == "*") begin
                  need_ref = 1'b1;
                  phase_d  = PH_OUT;
                end else begin
                  err_d = ST_BAD_KEY_EXPR;
                end
              end
              PH_RECV, PH_CHG: begin
                if (is_digit(c)) begin
                  lz_d  = (dc_q == 4'd0) ? (c == "0") : lz_q;
                  dc_d  = (dc_q < 4'd15) ? dc_q + 1'b1 : dc_q;
                  acc_d = acc_add(acc_q, 4'(c - "0"));
                end else begin
                  e = num_code(acc_q, dc_q, lz_q);
                  if (e != ST_OK) begin
                    err_d = e;
                  end else if (phase_q == PH_RECV) begin
                    recv_d = acc_q[30:0];
                    if (c == ";") begin
                      phase_d = PH_CHG;
                      acc_d   = '0;
                      dc_d    = '0;
                      lz_d    = 1'b0;
                    end else begin
                      err_d = ST_BAD_KEY_EXPR;
                    end
                  end else if (c == ">") begin
                    phase_d = PH_SLASH2;
                  end else begin
                    err_d = ST_BAD_KEY_EXPR;
                  end
                end
              end
              PH_SLASH2: begin
                if (c == "/") begin
                  phase_d = PH_STAR1;
                end else begin
                  err_d = ST_BAD_KEY_EXPR;
                end
              end
              PH_STAR1: begin
                if (c == "*") begin
                  need_ref = 1'b1;
                  r_recv   = recv_q;
                  r_chg    = acc_q[30:0];
                  phase_d  = PH_OUT;
                end else begin
                  err_d = ST_BAD_KEY_EXPR;
                end
              end
              default: begin
                err_d = ST_BAD_KEY_EXPR;
              end
            endcase
          end

          // Equal paths fail at once, others go through the table search
          if (need_ref && (r_recv == r_chg)) begin
            need_ref = 1'b0;
            err_d    = ST_OVERLAP;
          end

          // Text ends inside a reference
          if (item_i.last && (err_d == ST_OK) && (phase_d != PH_OUT)) begin
            if (phase_d == PH_KEY) begin
              e = key_code(acc_d, dc_d, lz_d, eff_keys_i, seen_d, nnk_d);
            end else if ((phase_d == PH_RECV) || (phase_d == PH_CHG)) begin
              e = num_code(acc_d, dc_d, lz_d);
            end
            err_d = (e != ST_OK) ? e : ST_BAD_KEY_EXPR;
          end

          if (need_ref) begin
            prec_d = r_recv;
            pchg_d = r_chg;
            ridx_d = '0;
            cmpv_d = 1'b0;
            st_d   = BK_SRCH;
          end else if (need_pop) begin
            st_d = BK_POP;
          end else begin
            s = fin_status(item_i.wt_status, err_d, item_i.last, depth_d != '0,
                           nnk_d, eff_keys_i);
            ov_d               = 1'b1;
            out_d              = '0;
            out_d.status       = s;
            out_d.done_res     = item_i.last;
            do_clear           = item_i.last;
          end
        end
      end
      BK_POP: begin
        top_d = stk_rdata;
        st_d  = BK_FIN;
      end
      BK_SRCH: begin
        if (cmpv_q && (pt_rdata[35:31] == key_q) &&
            ((pt_rdata[30:0] == prec_q) || (pt_rdata[30:0] == pchg_q))) begin
          err_d = ST_OVERLAP;
          st_d  = BK_FIN;
        end else if (ridx_q < pc_q) begin
          ridx_d = ridx_q + 1'b1;
          cmpv_d = 1'b1;
        end else if (cmpv_q) begin
          cmpv_d = 1'b0;
        end else if (rc_q >= RCW'(MAX_REFS)) begin
          err_d = ST_TOO_MANY_REFS;
          st_d  = BK_FIN;
        end else begin
          st_d = BK_WR1;
        end
      end
      BK_WR1: begin
        pt_we = 1'b1;
        pc_d  = pc_q + 1'b1;
        st_d  = BK_WR2;
      end
      BK_WR2: begin
        pt_we    = 1'b1;
        pt_wdata = {key_q, pchg_q};
        pc_d     = pc_q + 1'b1;
        rc_d     = rc_q + 1'b1;
        refv_d   = 1'b1;
        st_d     = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          s = fin_status(itm_q.wt_status, err_q, itm_q.last, depth_q != '0,
                         nnk_q, eff_keys_i);
          ov_d             = 1'b1;
          out_d            = '0;
          out_d.status     = s;
          out_d.done_res   = itm_q.last;
          if (refv_q) begin
            out_d.ref_valid   = 1'b1;
            out_d.ref_key     = key_q;
            out_d.ref_receive = prec_q;
            out_d.ref_change  = pchg_q;
          end
          refv_d   = 1'b0;
          do_clear = itm_q.last;
          st_d     = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase

    // Drop all text state after the final character
    if (do_clear) begin
      phase_d = PH_OUT;
      depth_d = '0;
      acc_d   = '0;
      dc_d    = '0;
      lz_d    = 1'b0;
      key_d   = '0;
      recv_d  = '0;
      seen_d  = '0;
      nnk_d   = '0;
      rc_d    = '0;
      pc_d    = '0;
      wr_d    = '0;
      err_d   = ST_OK;
    end
  end

  // Control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      phase_q <= PH_OUT;
      depth_q <= '0;
      top_q   <= 1'b0;
      acc_q   <= '0;
      dc_q    <= '0;
      lz_q    <= 1'b0;
      key_q   <= '0;
      recv_q  <= '0;
      seen_q  <= '0;
      nnk_q   <= '0;
      rc_q    <= '0;
      pc_q    <= '0;
      wr_q    <= '0;
      err_q   <= ST_OK;
      ridx_q  <= '0;
      cmpv_q  <= 1'b0;
      refv_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      depth_q <= depth_d;
      top_q   <= top_d;
      acc_q   <= acc_d;
      dc_q    <= dc_d;
      lz_q    <= lz_d;
      key_q   <= key_d;
      recv_q  <= recv_d;
      seen_q  <= seen_d;
      nnk_q   <= nnk_d;
      rc_q    <= rc_d;
      pc_q    <= pc_d;
      wr_q    <= wr_d;
      err_q   <= err_d;
      ridx_q  <= ridx_d;
      cmpv_q  <= cmpv_d;
      refv_q  <= refv_d;
      ov_q    <= ov_d;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk_i) begin
    itm_q  <= itm_d;
    prec_q <= prec_d;
    pchg_q <= pchg_d;
    out_q  <= out_d;
  end

endmodule

// ===== rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the policy text scanner, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker
  import pts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pts_out_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Reference fields are zero without a reference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ref_valid |->
      (out_data_o.ref_key == '0) && (out_data_o.ref_receive == '0) &&
      (out_data_o.ref_change == '0))
    else $error("reference fields set without a reference");

  // A reported reference never has equal paths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ref_valid |->
      out_data_o.ref_receive != out_data_o.ref_change)
    else $error("reference with equal paths");

  // Status code stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= 5'd16)
    else $error("status code out of range");

endmodule

bind policy_text_scanner pts_checker u_pts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
